[design/ffha_pkg.sv]
// Shared types, codes and constants for the first-fit heap allocator.
package ffha_pkg;

  localparam int ADDR_W     = 23;
  localparam int OUTCOME_W  = 3;
  localparam int CFG_IDX_W  = 2;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int GAP_BYTES_DEF    = 4;

  localparam logic [ADDR_W-1:0] HEAP_START_RESET = 23'h100000;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RESET = 23'h400000;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 2'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [OUTCOME_W-1:0] OC_REUSED   = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_APPENDED = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_ZERO     = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_NOMEM    = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_FREED    = 3'd4;
  localparam logic [OUTCOME_W-1:0] OC_BADFREE  = 3'd5;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    block_address;
    logic [OUTCOME_W-1:0] outcome;
    logic [ADDR_W-1:0]    bytes_in_use;
  } out_res_t;

  typedef struct packed {
    logic              used;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] footprint;
    logic [ADDR_W-1:0] data_addr;
  } cmp_res_t;

endpackage

[design/ffha_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[design/ffha_cmp_unit.sv]
// Shared compare and add unit that checks one table entry against the request.
module ffha_cmp_unit #(
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int GAP_BYTES    = ffha_pkg::GAP_BYTES_DEF
) (
  input  ffha_pkg::entry_t   entry,
  input  ffha_pkg::in_req_t  req,
  output ffha_pkg::cmp_res_t res
);
  import ffha_pkg::*;

  logic [ADDR_W:0] data_addr_w;

  always_comb begin
    data_addr_w   = {1'b0, entry.start} + (ADDR_W+1)'(HEADER_BYTES);
    res.data_addr = data_addr_w[ADDR_W-1:0];
    res.footprint = entry.size + ADDR_W'(HEADER_BYTES + GAP_BYTES);
    if (req.opcode == OP_ALLOC) begin
      res.hit = !entry.used && (entry.size >= req.request_size);
    end else begin
      res.hit = (data_addr_w == {1'b0, req.free_address});
    end
  end

endmodule

[design/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator: sequencer, state and result register.
//
//   Channel | Direction | Handshake          | Payload
//   in_     | input     | in_valid/in_stall  | in_req_t (opcode, size, address)
//   out_    | output    | out_valid/out_stall| out_res_t (address, outcome, bytes)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An allocate of size zero skips the table. Any other request reads one table entry per
// cycle through the table RAM and stops at the first entry read that matches; when none
// of the entries read matches, it goes on to an end step that appends or refuses it.
// Reset is synchronous and needs no clearing pass; the block count bounds all reads.
// A stalled result waits in the output register while the next request is taken.
module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF,
  parameter int GAP_BYTES    = ffha_pkg::GAP_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ffha_pkg::in_req_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ffha_pkg::out_res_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0]      cfg_data
);
  import ffha_pkg::*;

  localparam int IW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W = ADDR_W + 3;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_END  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [IW-1:0]        chk_r, chk_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [ADDR_W-1:0]    bump_r, bump_nxt;
  logic [ADDR_W-1:0]    used_r, used_nxt;
  logic [ADDR_W-1:0]    start_r, start_nxt;
  logic [ADDR_W-1:0]    limit_r, limit_nxt;
  in_req_t              req_r, req_nxt;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic [OUTCOME_W-1:0] res_oc_r, res_oc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_res_t             out_data_r, out_data_nxt;

  logic                 in_accept;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  entry_t               wr_entry;
  logic [IW-1:0]        rd_addr;
  entry_t               rd_entry;
  cmp_res_t             cmp;
  logic                 last_entry;
  logic [SUM_W-1:0]     data_end;
  logic [SUM_W-1:0]     end_gap;
  logic [SUM_W-1:0]     data_addr_new;
  logic                 nomem;
  logic [ADDR_W-1:0]    fp_new;

  ffha_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_BLOCKS),
    .AW    (IW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  ffha_cmp_unit #(
    .HEADER_BYTES (HEADER_BYTES),
    .GAP_BYTES    (GAP_BYTES)
  ) u_cmp (
    .entry (rd_entry),
    .req   (req_r),
    .res   (cmp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_addr    = (state_r == S_SCAN) ? chk_r + IW'(1) : '0;
  assign last_entry = (CW'(chk_r) + CW'(1)) == count_r;

  assign data_end      = SUM_W'(bump_r) + SUM_W'(HEADER_BYTES) + SUM_W'(req_r.request_size);
  assign end_gap       = data_end + SUM_W'(GAP_BYTES);
  assign data_addr_new = SUM_W'(bump_r) + SUM_W'(HEADER_BYTES);
  assign nomem         = (count_r >= CW'(MAX_BLOCKS)) || (data_end >= SUM_W'(limit_r)) ||
                         (end_gap > SUM_W'(limit_r));
  assign fp_new        = req_r.request_size + ADDR_W'(HEADER_BYTES + GAP_BYTES);

  always_comb begin
    state_nxt     = state_r;
    chk_nxt       = chk_r;
    count_nxt     = count_r;
    bump_nxt      = bump_r;
    used_nxt      = used_r;
    start_nxt     = start_r;
    limit_nxt     = limit_r;
    req_nxt       = req_r;
    res_addr_nxt  = res_addr_r;
    res_oc_nxt    = res_oc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = chk_r;
    wr_entry      = rd_entry;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          req_nxt = in_data;
          chk_nxt = '0;
          if (in_data.opcode == OP_ALLOC && in_data.request_size == '0) begin
            res_addr_nxt = '0;
            res_oc_nxt   = OC_ZERO;
            state_nxt    = S_DONE;
          end else if (count_r == '0) begin
            state_nxt = S_END;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cmp.hit) begin
          state_nxt = S_DONE;
          if (req_r.opcode == OP_ALLOC) begin
            wr_en         = 1'b1;
            wr_entry.used = 1'b1;
            used_nxt      = used_r + cmp.footprint;
            res_addr_nxt  = cmp.data_addr;
            res_oc_nxt    = OC_REUSED;
          end else if (rd_entry.used) begin
            wr_en         = 1'b1;
            wr_entry.used = 1'b0;
            used_nxt      = used_r - cmp.footprint;
            res_addr_nxt  = req_r.free_address;
            res_oc_nxt    = OC_FREED;
          end else begin
            res_addr_nxt = '0;
            res_oc_nxt   = OC_BADFREE;
          end
        end else if (last_entry) begin
          state_nxt = S_END;
        end else begin
          chk_nxt = chk_r + IW'(1);
        end
      end
      S_END: begin
        state_nxt = S_DONE;
        if (req_r.opcode == OP_FREE) begin
          res_addr_nxt = '0;
          res_oc_nxt   = OC_BADFREE;
        end else if (nomem) begin
          res_addr_nxt = '0;
          res_oc_nxt   = OC_NOMEM;
        end else begin
          wr_en          = 1'b1;
          wr_addr        = count_r[IW-1:0];
          wr_entry.used  = 1'b1;
          wr_entry.size  = req_r.request_size;
          wr_entry.start = bump_r;
          count_nxt      = count_r + CW'(1);
          bump_nxt       = end_gap[ADDR_W-1:0];
          used_nxt       = used_r + fp_new;
          res_addr_nxt   = data_addr_new[ADDR_W-1:0];
          res_oc_nxt     = OC_APPENDED;
        end
      end
      S_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.block_address = res_addr_r;
          out_data_nxt.outcome       = res_oc_r;
          out_data_nxt.bytes_in_use  = used_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HEAP_START: begin
          start_nxt = cfg_data;
          bump_nxt  = cfg_data;
          count_nxt = '0;
          used_nxt  = '0;
        end
        CFG_HEAP_LIMIT: begin
          limit_nxt = cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_r       <= '0;
      count_r     <= '0;
      bump_r      <= HEAP_START_RESET;
      used_r      <= '0;
      start_r     <= HEAP_START_RESET;
      limit_r     <= HEAP_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chk_r       <= chk_nxt;
      count_r     <= count_nxt;
      bump_r      <= bump_nxt;
      used_r      <= used_nxt;
      start_r     <= start_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_addr_r <= res_addr_nxt;
    res_oc_r   <= res_oc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[design/ffha_checker.sv]
// Port-level assertions for the first-fit heap allocator and their binding.
module ffha_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input ffha_pkg::out_res_t             out_data
);
  import ffha_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("A second request was taken before the first one finished.");

  a_outcome_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.outcome <= OC_BADFREE)
    else $error("Result carries an undefined outcome.");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.outcome == OC_ZERO || out_data.outcome == OC_NOMEM ||
                  out_data.outcome == OC_BADFREE) |-> out_data.block_address == '0)
    else $error("A refused request returned a nonzero address.");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for the first-fit heap allocator with its own table predictor.
`timescale 1ns / 100ps

module tb_top;
  import ffha_pkg::*;

  localparam int MAXB     = MAX_BLOCKS_DEF;
  localparam int HDR      = HEADER_BYTES_DEF;
  localparam int GAP      = GAP_BYTES_DEF;
  localparam int SETTLE   = MAX_BLOCKS_DEF + 16;
  localparam int IDLE_CAP = 4000;
  localparam int HOLD_LEN = 300;
  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_res_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  first_fit_heap_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted allocator state.
  logic [ADDR_W-1:0] heap_base;
  logic [ADDR_W-1:0] heap_cap;
  logic [ADDR_W-1:0] blk_start [MAXB];
  logic [ADDR_W-1:0] blk_size [MAXB];
  bit                blk_used [MAXB];
  int unsigned       blk_count;
  logic [ADDR_W-1:0] bump_ptr;
  logic [ADDR_W-1:0] bytes_taken;

  in_req_t  request_q [$];
  out_res_t result_q [$];
  bit       req_taken = 1'b0;
  bit       quiet = 1'b0;
  bit       hold_go = 1'b0;
  int       hold_left = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;

  function automatic void clear_heap();
    for (int i = 0; i < MAXB; i++) begin
      blk_start[i] = '0;
      blk_size[i]  = '0;
      blk_used[i]  = 1'b0;
    end
    blk_count   = 0;
    bump_ptr    = heap_base;
    bytes_taken = '0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    case (idx)
      CFG_HEAP_START: begin
        heap_base = val;
        clear_heap();
      end
      CFG_HEAP_LIMIT: begin
        heap_cap = val;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic out_res_t serve_request(in_req_t rq);
    out_res_t res;
    bit       found;
    longint   data_end;
    res = '0;
    found = 1'b0;
    if (rq.opcode == OP_ALLOC) begin
      if (rq.request_size == '0) begin
        res.outcome = OC_ZERO;
      end else begin
        for (int i = 0; i < blk_count; i++) begin
          if (!found && !blk_used[i] && blk_size[i] >= rq.request_size) begin
            blk_used[i] = 1'b1;
            bytes_taken = ADDR_W'(bytes_taken + blk_size[i] + HDR + GAP);
            res.block_address = ADDR_W'(blk_start[i] + HDR);
            found = 1'b1;
          end
        end
        if (found) begin
          res.outcome = OC_REUSED;
        end else begin
          data_end = longint'(bump_ptr) + HDR + longint'(rq.request_size);
          if (blk_count >= MAXB || data_end >= longint'(heap_cap) ||
              data_end + GAP > longint'(heap_cap)) begin
            res.outcome = OC_NOMEM;
          end else begin
            blk_start[blk_count] = bump_ptr;
            blk_size[blk_count]  = rq.request_size;
            blk_used[blk_count]  = 1'b1;
            blk_count++;
            res.block_address = ADDR_W'(bump_ptr + HDR);
            bump_ptr = ADDR_W'(data_end + GAP);
            bytes_taken = ADDR_W'(bytes_taken + rq.request_size + HDR + GAP);
            res.outcome = OC_APPENDED;
          end
        end
      end
    end else begin
      res.outcome = OC_BADFREE;
      for (int i = 0; i < blk_count; i++) begin
        if (!found && longint'(blk_start[i]) + HDR == longint'(rq.free_address)) begin
          found = 1'b1;
          if (blk_used[i]) begin
            blk_used[i] = 1'b0;
            bytes_taken = ADDR_W'(bytes_taken - blk_size[i] - HDR - GAP);
            res.block_address = rq.free_address;
            res.outcome = OC_FREED;
          end
        end
      end
    end
    res.bytes_in_use = bytes_taken;
    return res;
  endfunction

  function automatic in_req_t make_req(logic op, logic [ADDR_W-1:0] size,
                                       logic [ADDR_W-1:0] addr);
    in_req_t rq;
    rq.opcode       = op;
    rq.request_size = size;
    rq.free_address = addr;
    return rq;
  endfunction

  function automatic in_req_t random_req();
    in_req_t rq;
    int      pick;
    int      idx;
    pick = $urandom_range(0, 99);
    rq.opcode       = OP_ALLOC;
    rq.request_size = ADDR_W'($urandom());
    rq.free_address = ADDR_W'($urandom());
    if (pick < 50) begin
      case ($urandom_range(0, 9))
        0: rq.request_size = '0;
        1: rq.request_size = ADDR_W'($urandom_range(0, ADDR_MAX));
        2, 3: rq.request_size = ADDR_W'($urandom_range(1, 4096));
        4: begin
          if (blk_count != 0) begin
            idx = $urandom_range(0, blk_count - 1);
            rq.request_size = blk_size[idx];
          end else begin
            rq.request_size = ADDR_W'($urandom_range(1, 64));
          end
        end
        default: rq.request_size = ADDR_W'($urandom_range(1, 64));
      endcase
    end else begin
      rq.opcode = OP_FREE;
      if (pick < 88 && blk_count != 0) begin
        idx = $urandom_range(0, blk_count - 1);
        rq.free_address = ADDR_W'(blk_start[idx] + HDR);
      end else if (pick < 94 && blk_count != 0) begin
        idx = $urandom_range(0, blk_count - 1);
        rq.free_address = ADDR_W'(blk_start[idx] + HDR + ($urandom_range(0, 1) ? 1 : -1));
      end
    end
    return rq;
  endfunction

  // Sender: offers the next pending request once the previous one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (request_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 8)) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 8);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: addr=%h outcome=%0d bytes=%h",
                     out_data.block_address, out_data.outcome, out_data.bytes_in_use);
          end
        end else begin
          out_res_t want;
          want = result_q.pop_front();
          if (out_data.block_address !== want.block_address ||
              out_data.outcome !== want.outcome ||
              out_data.bytes_in_use !== want.bytes_in_use) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp addr=%h oc=%0d bytes=%h, got addr=%h oc=%0d bytes=%h",
                       want.block_address, want.outcome, want.bytes_in_use,
                       out_data.block_address, out_data.outcome, out_data.bytes_in_use);
            end
          end
        end
      end
      req_taken = in_valid && !in_stall;
      if (req_taken) begin
        result_q.push_back(serve_request(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_CAP) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (request_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_heap(logic [ADDR_W-1:0] start, logic [ADDR_W-1:0] limit);
    write_reg(CFG_HEAP_START, start);
    write_reg(CFG_HEAP_LIMIT, limit);
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      do begin
        @(posedge clk);
        #1;
      end while (request_q.size() >= 2);
      request_q.push_back(random_req());
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] base;
    heap_base = HEAP_START_RESET;
    heap_cap  = HEAP_LIMIT_RESET;
    clear_heap();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    request_q.push_back(make_req(OP_ALLOC, '0, ADDR_MAX));
    request_q.push_back(make_req(OP_FREE, ADDR_MAX, 23'h100008));
    request_q.push_back(make_req(OP_ALLOC, 23'd16, '0));
    request_q.push_back(make_req(OP_ALLOC, 23'd1, '0));
    request_q.push_back(make_req(OP_FREE, '0, 23'h100008));
    request_q.push_back(make_req(OP_FREE, '0, 23'h100008));
    request_q.push_back(make_req(OP_ALLOC, 23'd8, '0));
    request_q.push_back(make_req(OP_ALLOC, ADDR_MAX, '0));
    request_q.push_back(make_req(OP_ALLOC, 23'd17, '0));
    request_q.push_back(make_req(OP_FREE, '0, ADDR_MAX));
    request_q.push_back(make_req(OP_FREE, '0, 23'h100009));

    // A 64-byte heap at address zero puts both limit checks right at the edge.
    set_heap('0, 23'd64);
    request_q.push_back(make_req(OP_ALLOC, 23'd53, '0));
    request_q.push_back(make_req(OP_ALLOC, 23'd56, '0));
    request_q.push_back(make_req(OP_ALLOC, 23'd52, '0));
    request_q.push_back(make_req(OP_ALLOC, 23'd1, '0));
    request_q.push_back(make_req(OP_FREE, '0, 23'd8));
    request_q.push_back(make_req(OP_ALLOC, 23'd52, '0));
    request_q.push_back(make_req(OP_ALLOC, 23'd53, '0));
    request_q.push_back(make_req(OP_FREE, '0, 23'd8));

    // Lowering the limit alone keeps the table, so reuse still succeeds.
    write_reg(CFG_HEAP_LIMIT, '0);
    request_q.push_back(make_req(OP_ALLOC, 23'd1, '0));
    request_q.push_back(make_req(OP_ALLOC, 23'd60, '0));
    request_q.push_back(make_req(OP_FREE, '0, 23'd8));

    write_reg(CFG_SPARE_A, ADDR_W'($urandom()));
    write_reg(CFG_SPARE_B, ADDR_W'($urandom()));
    set_heap(HEAP_START_RESET, HEAP_LIMIT_RESET);
    hold_go = 1'b1;
    run_random(300);

    set_heap('0, ADDR_MAX);
    quiet = 1'b1;
    run_random(300);
    wait_drained();
    quiet = 1'b0;

    base = ADDR_W'($urandom_range(0, 23'h3FFFFF));
    set_heap(base, base + ADDR_W'($urandom_range(200, 3000)));
    run_random(300);
    write_reg(CFG_HEAP_LIMIT, base + ADDR_W'($urandom_range(4000, 60000)));
    run_random(200);

    set_heap(ADDR_MAX, ADDR_MAX);
    run_random(60);

    set_heap(23'h7FFF00, ADDR_MAX);
    run_random(100);

    set_heap('0, '0);
    run_random(40);

    set_heap(ADDR_W'($urandom()), ADDR_W'($urandom()));
    run_random(200);

    set_heap(HEAP_START_RESET, HEAP_LIMIT_RESET);
    run_random(400);

    wait_drained();
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[first_fit_heap_allocator.f]
design/ffha_pkg.sv
design/ffha_ram.sv
design/ffha_cmp_unit.sv
design/first_fit_heap_allocator.sv
design/ffha_checker.sv
dv/tb_top.sv
